// ===== rtl/sector_cache_tag_clock_replacement_assert.svh =====
// assertion macros for the sector cache tag store
`ifndef SECTOR_CACHE_TAG_CLOCK_REPLACEMENT_ASSERT_SVH
`define SECTOR_CACHE_TAG_CLOCK_REPLACEMENT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SCTCR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sector cache assertion failed");
`define SCTCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sector cache assertion failed");
`else
`define SCTCR_ASSERT_IMPLIES(lbl, ante, cons)
`define SCTCR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/sctcr_pkg.sv =====
package sctcr_pkg;

    localparam int SLOT_COUNT_DEF   = 64;
    localparam int COUNTER_BITS_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic compare;
        logic hit_upd;
        logic fill_empty;
        logic sweep_init;
        logic sweep_step;
        logic evict;
        logic flush_step;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_flush;
        logic in_none;
        logic any_match;
        logic any_empty;
        logic victim_found;
        logic flush_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/sctcr_prio.sv =====
module sctcr_prio #(
    parameter int WIDTH = 64,
    parameter int IDX_W = $clog2(WIDTH)
) (
    input  logic [WIDTH-1:0] i_vec,
    output logic             o_any,
    output logic [IDX_W-1:0] o_idx
);

    // lowest set bit wins
    always_comb begin
        o_any = |i_vec;
        o_idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/sctcr_ctrl.sv =====
module sctcr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sctcr_pkg::t_dp_stat i_stat,
    output sctcr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RESOLVE,
        ST_SWEEP,
        ST_EVICT,
        ST_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_flush) begin
                        n_state = ST_FLUSH;
                    end else if (!i_stat.in_none) begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (i_stat.any_match) begin
                    if (i_stat.out_free) begin
                        o_cmd.hit_upd = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (i_stat.any_empty) begin
                    if (i_stat.out_free) begin
                        o_cmd.fill_empty = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    o_cmd.sweep_init = 1'b1;
                    n_state          = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (i_stat.victim_found) begin
                    n_state = ST_EVICT;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            ST_EVICT: begin
                if (i_stat.out_free) begin
                    o_cmd.evict = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.flush_step = 1'b1;
                    if (i_stat.flush_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/sctcr_dp.sv =====
module sctcr_dp #(
    parameter int SLOT_COUNT   = sctcr_pkg::SLOT_COUNT_DEF,
    parameter int COUNTER_BITS = sctcr_pkg::COUNTER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sctcr_pkg::t_dp_cmd               i_cmd,
    output sctcr_pkg::t_dp_stat              o_stat,
    input  logic [sctcr_pkg::CMD_W-1:0]      i_in_cmd,
    input  logic [sctcr_pkg::SECTOR_W-1:0]   i_in_sector,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_hit,
    output logic [sctcr_pkg::SLOT_W-1:0]     o_slot,
    output logic                             o_fill,
    output logic                             o_wbv,
    output logic [sctcr_pkg::SECTOR_W-1:0]   o_wbs,
    output logic                             o_last
);

    localparam int              IDX_W     = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    // tag store, one comparator per row
    logic [sctcr_pkg::SECTOR_W-1:0] r_tag [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]          r_valid;
    logic [SLOT_COUNT-1:0]          r_dirty;
    logic [COUNTER_BITS-1:0]        r_count [SLOT_COUNT];
    logic [IDX_W-1:0]               r_hand;
    logic                           r_started;

    logic [sctcr_pkg::CMD_W-1:0]    r_cmd;
    logic [sctcr_pkg::SECTOR_W-1:0] r_sector;
    logic [SLOT_COUNT-1:0]          r_match;
    logic [IDX_W-1:0]               r_pos;
    logic                           r_bounded;

    logic                           r_out_valid;
    logic                           r_hit;
    logic [IDX_W-1:0]               r_slot;
    logic                           r_fill;
    logic                           r_wbv;
    logic [sctcr_pkg::SECTOR_W-1:0] r_wbs;
    logic                           r_last;

    logic [SLOT_COUNT-1:0]   w_dirty_vec;
    logic [SLOT_COUNT-1:0]   w_dirty_rest;
    logic                    w_any_match;
    logic [IDX_W-1:0]        w_match_idx;
    logic                    w_any_empty;
    logic [IDX_W-1:0]        w_empty_idx;
    logic                    w_any_dirty;
    logic [IDX_W-1:0]        w_flush_idx;
    logic [COUNTER_BITS-1:0] w_pos_count;
    logic [IDX_W-1:0]        w_pos_next;
    logic [IDX_W-1:0]        w_hand_next;
    logic                    w_out_free;
    logic                    w_emit;
    logic                    w_is_read;
    logic                    w_is_write;

    assign w_dirty_vec  = r_valid & r_dirty;
    // drop the lowest dirty slot to see whether more follow
    assign w_dirty_rest = w_dirty_vec & (w_dirty_vec - 1'b1);
    assign w_pos_count  = r_count[r_pos];
    assign w_pos_next   = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;
    assign w_hand_next  = (r_hand == LAST_SLOT) ? '0 : r_hand + 1'b1;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_emit       = i_cmd.hit_upd || i_cmd.fill_empty || i_cmd.evict || i_cmd.flush_step;
    assign w_is_read    = (r_cmd == sctcr_pkg::CMD_READ);
    assign w_is_write   = (r_cmd == sctcr_pkg::CMD_WRITE);

    sctcr_prio #(.WIDTH(SLOT_COUNT), .IDX_W(IDX_W)) u_match_prio (
        .i_vec (r_match),
        .o_any (w_any_match),
        .o_idx (w_match_idx)
    );

    sctcr_prio #(.WIDTH(SLOT_COUNT), .IDX_W(IDX_W)) u_empty_prio (
        .i_vec (~r_valid),
        .o_any (w_any_empty),
        .o_idx (w_empty_idx)
    );

    sctcr_prio #(.WIDTH(SLOT_COUNT), .IDX_W(IDX_W)) u_flush_prio (
        .i_vec (w_dirty_vec),
        .o_any (w_any_dirty),
        .o_idx (w_flush_idx)
    );

    always_comb begin
        o_stat.in_flush     = (i_in_cmd == sctcr_pkg::CMD_FLUSH);
        o_stat.in_none      = !((i_in_cmd == sctcr_pkg::CMD_READ)
                                || (i_in_cmd == sctcr_pkg::CMD_WRITE)
                                || (i_in_cmd == sctcr_pkg::CMD_FLUSH));
        o_stat.any_match    = w_any_match;
        o_stat.any_empty    = w_any_empty;
        // a bounded sweep ends back at the hand, and the hand's slot goes
        o_stat.victim_found = (r_bounded && (r_pos == r_hand)) || (w_pos_count == '0);
        o_stat.flush_last   = (w_dirty_rest == '0);
        o_stat.out_free     = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_count[i] <= '0;
            end
            r_hand      <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.hit_upd) begin
                if (r_count[w_match_idx] != '1) begin
                    r_count[w_match_idx] <= r_count[w_match_idx] + 1'b1;
                end
                if (w_is_write) begin
                    r_dirty[w_match_idx] <= 1'b1;
                end
            end
            if (i_cmd.fill_empty) begin
                r_valid[w_empty_idx] <= 1'b1;
                r_dirty[w_empty_idx] <= w_is_write;
                r_count[w_empty_idx] <= COUNTER_BITS'(1);
            end
            if (i_cmd.sweep_step) begin
                r_count[r_pos] <= w_pos_count - 1'b1;
            end
            if (i_cmd.evict) begin
                r_valid[r_pos] <= 1'b1;
                r_dirty[r_pos] <= w_is_write;
                r_count[r_pos] <= COUNTER_BITS'(1);
                r_hand         <= r_pos;
                r_started      <= 1'b1;
            end
            if (i_cmd.flush_step && w_any_dirty) begin
                r_valid[w_flush_idx] <= 1'b0;
                r_dirty[w_flush_idx] <= 1'b0;
                r_count[w_flush_idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= i_in_cmd;
            r_sector <= i_in_sector;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_match[i] <= r_valid[i] && (r_tag[i] == r_sector);
            end
        end
        if (i_cmd.sweep_init) begin
            r_pos     <= r_started ? w_hand_next : '0;
            r_bounded <= r_started;
        end
        if (i_cmd.sweep_step) begin
            r_pos <= w_pos_next;
        end
        if (i_cmd.fill_empty) begin
            r_tag[w_empty_idx] <= r_sector;
        end
        if (i_cmd.evict) begin
            r_tag[r_pos] <= r_sector;
        end

        if (i_cmd.hit_upd) begin
            r_hit  <= 1'b1;
            r_slot <= w_match_idx;
            r_fill <= 1'b0;
            r_wbv  <= 1'b0;
            r_wbs  <= '0;
            r_last <= 1'b1;
        end
        if (i_cmd.fill_empty) begin
            r_hit  <= 1'b0;
            r_slot <= w_empty_idx;
            r_fill <= w_is_read;
            r_wbv  <= 1'b0;
            r_wbs  <= '0;
            r_last <= 1'b1;
        end
        if (i_cmd.evict) begin
            r_hit  <= 1'b0;
            r_slot <= r_pos;
            r_fill <= w_is_read;
            r_wbv  <= 1'b1;
            r_wbs  <= r_tag[r_pos];
            r_last <= 1'b1;
        end
        if (i_cmd.flush_step) begin
            r_hit  <= 1'b0;
            r_slot <= w_any_dirty ? w_flush_idx : '0;
            r_fill <= 1'b0;
            r_wbv  <= w_any_dirty;
            r_wbs  <= w_any_dirty ? r_tag[w_flush_idx] : '0;
            r_last <= (w_dirty_rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_slot      = sctcr_pkg::SLOT_W'(r_slot);
    assign o_fill      = r_fill;
    assign o_wbv       = r_wbv;
    assign o_wbs       = r_wbs;
    assign o_last      = r_last;

endmodule

// ===== rtl/sector_cache_tag_clock_replacement.sv =====
// hit or empty-slot miss: beat registered, ST_CMP, then ST_RESOLVE once the
// output is free; clock eviction: sweep a slot at a time from after the hand
// (first sweep from 0 can lap the ring until a use counter drains to zero);
// flush: one result a cycle while output is free; new beats taken when idle
// reset (synchronous, active low): all slots empty, counters zero, hand at 0,
// tags stay unknown; no clearing pass
`include "sector_cache_tag_clock_replacement_assert.svh"

module sector_cache_tag_clock_replacement #(
    parameter int SLOT_COUNT   = sctcr_pkg::SLOT_COUNT_DEF,
    parameter int COUNTER_BITS = sctcr_pkg::COUNTER_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sector[31:0]
    input  logic [sctcr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // cmd[1:0]
    input  logic [sctcr_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // slot[5:0], writeback_sector[37:6], zero[39:38]
    output logic [sctcr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // hit[0], fill_needed[1], writeback_valid[2]
    output logic [sctcr_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    sctcr_pkg::t_dp_cmd  w_cmd;
    sctcr_pkg::t_dp_stat w_stat;

    logic                             w_hit;
    logic [sctcr_pkg::SLOT_W-1:0]     w_slot;
    logic                             w_fill;
    logic                             w_wbv;
    logic [sctcr_pkg::SECTOR_W-1:0]   w_wbs;

    sctcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sctcr_dp #(
        .SLOT_COUNT   (SLOT_COUNT),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_sector (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_hit       (w_hit),
        .o_slot      (w_slot),
        .o_fill      (w_fill),
        .o_wbv       (w_wbv),
        .o_wbs       (w_wbs),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_wbs, w_slot};
    assign o_m_axis_tuser = {w_wbv, w_fill, w_hit};

    `SCTCR_ASSERT_NEXT(a_busy_after_accept, w_cmd.accept && !w_stat.in_none, !o_s_axis_tready)
    `SCTCR_ASSERT_IMPLIES(a_hit_is_single, o_m_axis_tvalid && w_hit, o_m_axis_tlast && !w_fill && !w_wbv)
    `SCTCR_ASSERT_IMPLIES(a_no_wb_sector_zero, o_m_axis_tvalid && !w_wbv, w_wbs == '0)

endmodule
